// File: hdl/fpd_pkg.sv
// fpd_pkg: shared types and constants for the flight phase detector
// stage codes, dwell limits, register indexes and reset values
// no dependencies
package fpd_pkg;

	localparam logic [2:0] PH_GROUND = 3'd0;
	localparam logic [2:0] PH_BOOST  = 3'd1;
	localparam logic [2:0] PH_COAST  = 3'd2;
	localparam logic [2:0] PH_DROGUE = 3'd3;
	localparam logic [2:0] PH_MAIN   = 3'd4;
	localparam logic [2:0] PH_LANDED = 3'd5;

	localparam logic [1:0] LOG_NONE   = 2'd0;
	localparam logic [1:0] LOG_FLIGHT = 2'd1;
	localparam logic [1:0] LOG_GROUND = 2'd2;

	localparam logic [31:0] DWELL_DROGUE_MS = 32'd5000;
	localparam logic [31:0] DWELL_MAIN_MS   = 32'd15000;
	localparam logic [31:0] DWELL_LAND_MS   = 32'd10000;
	localparam logic [31:0] DWELL_LANDED_MS = 32'd5000;

	// 3.28 ft per m in unsigned q3.16
	localparam logic [18:0] FEET_PER_M_Q16 = 19'd214958;

	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_HEIGHT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_BARO     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_ACCEL    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COAST_ACCEL     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAIN_FEET       = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LANDING_HEIGHT  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LANDING_SPEED   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FLIGHT_TIMEOUT  = 4'd7;

	localparam logic [30:0] RST_LAUNCH_HEIGHT  = 31'd131072;
	localparam logic [30:0] RST_LAUNCH_BARO    = 31'd655360;
	localparam logic [30:0] RST_LAUNCH_ACCEL   = 31'd655360;
	localparam logic [30:0] RST_COAST_ACCEL    = 31'd655360;
	localparam logic [15:0] RST_MAIN_FEET      = 16'd700;
	localparam logic [30:0] RST_LANDING_HEIGHT = 31'd1310720;
	localparam logic [31:0] RST_LANDING_SPEED  = 32'd262144;
	localparam logic [31:0] RST_FLIGHT_TIMEOUT = 32'd600000;

	typedef struct packed {
		logic [30:0]        launch_height;
		logic [30:0]        launch_baro_height;
		logic [30:0]        launch_accel;
		logic [30:0]        coast_accel;
		logic [15:0]        main_height_feet;
		logic [30:0]        landing_height;
		logic signed [31:0] landing_speed;
		logic [31:0]        flight_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] launch_time;
		logic [31:0] last_change_time;
	} track_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [31:0] height;
		logic signed [31:0] vert_speed;
		logic signed [31:0] vert_accel;
		logic signed [31:0] baro_height;
	} sample_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [2:0]  beeps;
		logic [1:0]  log_mode;
		logic [31:0] since_launch_ms;
	} result_t;

endpackage

// File: hdl/fpd_rules.sv
// fpd_rules: stage transition rules for one sensor sample, purely combinational
// depends on fpd_pkg
module fpd_rules (
	input  fpd_pkg::cfg_t    cfg,
	input  fpd_pkg::track_t  cur,
	input  fpd_pkg::sample_t smp,
	output fpd_pkg::track_t  nxt,
	output fpd_pkg::result_t res
);

	logic [31:0]        since;
	logic [31:0]        dwell;
	logic [32:0]        accel_mag;
	logic signed [50:0] feet_prod;
	logic signed [50:0] feet_limit;
	logic               go_boost;
	logic               go_coast;
	logic               go_drogue;
	logic               go_main;
	logic               go_landed;
	logic               go_ground;

	assign since = smp.now_ms - cur.launch_time;
	assign dwell = smp.now_ms - cur.last_change_time;

	// 33 bits so the most negative input has a magnitude
	assign accel_mag = smp.vert_accel[31] ? (33'd0 - {smp.vert_accel[31], smp.vert_accel})
	                                      : {1'b0, smp.vert_accel};

	assign feet_prod  = {{19{smp.height[31]}}, smp.height}
	                  * $signed({32'd0, fpd_pkg::FEET_PER_M_Q16});
	assign feet_limit = $signed({3'd0, cfg.main_height_feet, 32'd0});

	assign go_boost  = (cur.phase == fpd_pkg::PH_GROUND) &&
	                   ((smp.height > $signed({1'b0, cfg.launch_height})) ||
	                    ((smp.baro_height > $signed({1'b0, cfg.launch_baro_height})) &&
	                     (smp.vert_accel > $signed({1'b0, cfg.launch_accel}))));
	assign go_coast  = (cur.phase == fpd_pkg::PH_BOOST) &&
	                   (accel_mag < {2'd0, cfg.coast_accel});
	assign go_drogue = (cur.phase == fpd_pkg::PH_COAST) && smp.vert_speed[31] &&
	                   (dwell > fpd_pkg::DWELL_DROGUE_MS);
	assign go_main   = (cur.phase == fpd_pkg::PH_DROGUE) && (feet_prod < feet_limit) &&
	                   (dwell > fpd_pkg::DWELL_MAIN_MS);
	assign go_landed = (cur.phase == fpd_pkg::PH_MAIN) &&
	                   (smp.vert_speed < cfg.landing_speed) &&
	                   (smp.height < $signed({1'b0, cfg.landing_height})) &&
	                   (dwell > fpd_pkg::DWELL_LAND_MS);
	assign go_ground = ((cur.phase == fpd_pkg::PH_LANDED) && (dwell > fpd_pkg::DWELL_LANDED_MS))
	                || ((cur.phase != fpd_pkg::PH_GROUND) && (since > cfg.flight_timeout_ms));

	always_comb begin
		nxt = cur;
		res.beeps = 3'd0;
		res.log_mode = fpd_pkg::LOG_NONE;
		priority if (go_boost) begin
			nxt.phase = fpd_pkg::PH_BOOST;
			nxt.launch_time = smp.now_ms;
			nxt.last_change_time = smp.now_ms;
			res.beeps = fpd_pkg::PH_BOOST;
			res.log_mode = fpd_pkg::LOG_FLIGHT;
		end else if (go_coast) begin
			nxt.phase = fpd_pkg::PH_COAST;
			nxt.last_change_time = smp.now_ms;
			res.beeps = fpd_pkg::PH_COAST;
		end else if (go_drogue) begin
			nxt.phase = fpd_pkg::PH_DROGUE;
			nxt.last_change_time = smp.now_ms;
			res.beeps = fpd_pkg::PH_DROGUE;
		end else if (go_main) begin
			nxt.phase = fpd_pkg::PH_MAIN;
			nxt.last_change_time = smp.now_ms;
			res.beeps = fpd_pkg::PH_MAIN;
		end else if (go_landed) begin
			nxt.phase = fpd_pkg::PH_LANDED;
			nxt.last_change_time = smp.now_ms;
			res.beeps = fpd_pkg::PH_LANDED;
		end else if (go_ground) begin
			// return to ground keeps the last change time
			nxt.phase = fpd_pkg::PH_GROUND;
			res.log_mode = fpd_pkg::LOG_GROUND;
		end else begin
			nxt = cur;
		end
		res.phase = nxt.phase;
		res.since_launch_ms = since;
	end

endmodule

// File: hdl/flight_phase_detector_core.sv
// flight_phase_detector_core: top level of the rocket flight stage detector
// holds config registers, input and result registers and the stage state
// depends on fpd_pkg and fpd_rules
//
// One sample request is taken per clock cycle while in_stall is low. Its result is offered on
// the output after the request passes the input register, then the result register. Throughput
// is one request per cycle while nothing stalls, set by the combinational rule evaluation that
// updates the stage, launch time and last change time.
// The input register holds a request while the result register is stalled, so in_stall
// rises only when both are full. Config writes are always ready and take effect at once;
// write them only while no request is in flight.
module flight_phase_detector_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [31:0]                        now_ms,
	input  logic signed [31:0]                 height,
	input  logic signed [31:0]                 vert_speed,
	input  logic signed [31:0]                 vert_accel,
	input  logic signed [31:0]                 baro_height,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         phase,
	output logic [2:0]                         beeps,
	output logic [1:0]                         log_mode,
	output logic [31:0]                        since_launch_ms,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                        cfg_data
);

	fpd_pkg::cfg_t    cfg_q;
	fpd_pkg::track_t  track_q;
	fpd_pkg::track_t  track_nxt;
	fpd_pkg::sample_t smp_s1;
	fpd_pkg::result_t res_nxt;
	fpd_pkg::result_t res_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;
	logic             in_accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.launch_height      <= fpd_pkg::RST_LAUNCH_HEIGHT;
			cfg_q.launch_baro_height <= fpd_pkg::RST_LAUNCH_BARO;
			cfg_q.launch_accel       <= fpd_pkg::RST_LAUNCH_ACCEL;
			cfg_q.coast_accel        <= fpd_pkg::RST_COAST_ACCEL;
			cfg_q.main_height_feet   <= fpd_pkg::RST_MAIN_FEET;
			cfg_q.landing_height     <= fpd_pkg::RST_LANDING_HEIGHT;
			cfg_q.landing_speed      <= fpd_pkg::RST_LANDING_SPEED;
			cfg_q.flight_timeout_ms  <= fpd_pkg::RST_FLIGHT_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fpd_pkg::REG_LAUNCH_HEIGHT:  cfg_q.launch_height      <= cfg_data[30:0];
				fpd_pkg::REG_LAUNCH_BARO:    cfg_q.launch_baro_height <= cfg_data[30:0];
				fpd_pkg::REG_LAUNCH_ACCEL:   cfg_q.launch_accel       <= cfg_data[30:0];
				fpd_pkg::REG_COAST_ACCEL:    cfg_q.coast_accel        <= cfg_data[30:0];
				fpd_pkg::REG_MAIN_FEET:      cfg_q.main_height_feet   <= cfg_data[15:0];
				fpd_pkg::REG_LANDING_HEIGHT: cfg_q.landing_height     <= cfg_data[30:0];
				fpd_pkg::REG_LANDING_SPEED:  cfg_q.landing_speed      <= cfg_data;
				fpd_pkg::REG_FLIGHT_TIMEOUT: cfg_q.flight_timeout_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register takes the sample when empty or being drained
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			smp_s1.now_ms      <= now_ms;
			smp_s1.height      <= height;
			smp_s1.vert_speed  <= vert_speed;
			smp_s1.vert_accel  <= vert_accel;
			smp_s1.baro_height <= baro_height;
		end
	end

	fpd_rules u_rules (
		.cfg (cfg_q),
		.cur (track_q),
		.smp (smp_s1),
		.nxt (track_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q.phase            <= fpd_pkg::PH_GROUND;
			track_q.launch_time      <= 32'd0;
			track_q.last_change_time <= 32'd0;
		end else if (advance) begin
			track_q <= track_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign phase           = res_q.phase;
	assign beeps           = res_q.beeps;
	assign log_mode        = res_q.log_mode;
	assign since_launch_ms = res_q.since_launch_ms;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		track_q.phase <= fpd_pkg::PH_LANDED)
		else $error("stage register out of range");

	a_beeps_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.beeps != 3'd0) |-> (res_q.beeps == res_q.phase))
		else $error("beep count does not match new stage");

	a_ground_log: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.log_mode == fpd_pkg::LOG_GROUND) |->
		(res_q.phase == fpd_pkg::PH_GROUND && res_q.beeps == 3'd0))
		else $error("return to ground with wrong stage or beeps");

	a_launch_time: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nxt.log_mode == fpd_pkg::LOG_FLIGHT) |=>
		(track_q.launch_time == track_q.last_change_time &&
		 track_q.phase == fpd_pkg::PH_BOOST))
		else $error("launch did not record launch time");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(track_q))
		else $error("stage state changed without a request");

endmodule
